>>> hdl/assert_macros.svh
// assertion macros shared by the rtl files
// expects clk and rst_n in the scope of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lphm_pkg.sv
// shared types and constants for the linear probe hash map
// no dependencies
package lphm_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int ENTRY_W     = 7;
    localparam int DEF_CAPACITY = 64;

    localparam logic [31:0] HASH_MULT = 32'h85eb_ca6b;

    localparam logic [1:0] FUNC_SET  = 2'd0;
    localparam logic [1:0] FUNC_GET  = 2'd1;
    localparam logic [1:0] FUNC_DEL  = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value_in;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [VAL_W-1:0]   value_out;
        logic               status;
        logic [ENTRY_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
    } hash_req_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

>>> hdl/lphm_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module lphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/lphm_hash.sv
// key hash and probe start slot: multiply, mix, then keep the low bits plus one
// depends on lphm_pkg and assert_macros.svh
`include "assert_macros.svh"

module lphm_hash
    import lphm_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hash_req_t                   hreq,
    output logic                        done,
    output logic [$clog2(CAPACITY)-1:0] slot
);

    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_MUL  = 3'b010,
        H_MIX  = 3'b100
    } hstate_t;

    hstate_t           state_reg, state_next;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  prod_reg;
    logic [IW-1:0]     rem_reg;
    logic              done_reg;
    logic [KEY_W-1:0]  mixed;

    assign mixed = prod_reg ^ (prod_reg >> 16);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (hreq.start)
                begin
                    state_next = H_MUL;
                end
            end
            H_MUL:   state_next = H_MIX;
            H_MIX:   state_next = H_IDLE;
            default: state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == H_MIX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == H_IDLE && hreq.start)
        begin
            key_reg <= hreq.key;
        end
        if (state_reg == H_MUL)
        begin
            prod_reg <= 32'(key_reg * HASH_MULT);
        end
        if (state_reg == H_MIX)
        begin
            rem_reg <= mixed[IW-1:0] + IW'(1);
        end
    end

    assign done = done_reg;
    assign slot = rem_reg;

    `ASSERT_SAME(a_start_when_idle, hreq.start, state_reg == H_IDLE, "hash started while busy")
    `ASSERT_NEXT(a_done_single, done_reg, !done_reg, "hash done held over two cycles")
    `ASSERT_SAME(a_slot_in_range, done_reg, rem_reg <= IW'(CAPACITY - 1), "start slot out of range")
    `ASSERT_SAME(a_capacity_pow2, 1'b1, (CAPACITY & (CAPACITY - 1)) == 0, "capacity not a power of two")

endmodule

>>> hdl/linear_probe_hash_map.sv
// Open addressing hash table with linear probing, CAPACITY slots of 32-bit key and value.
// CAPACITY must be a power of two: the start slot is the low bits of the hash plus one.
// After reset a clearing pass writes every slot, with req_stall high.
// One request is worked at a time: hash multiply, mix and start slot, then a scan
// that reads one slot per cycle from the slot ram, ending early on a key match, then
// the write step and the idle step before the next transfer. A miss or an insert of
// a new key scans every slot; an unused code skips hash and scan. A result that
// cannot leave the output register holds the write step until it does.
// The result sits in an output register, so the next request is taken while it waits.
// Depends on lphm_pkg, lphm_hash, lphm_ram and assert_macros.svh.
`include "assert_macros.svh"

module linear_probe_hash_map
    import lphm_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_WRITE = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [IW-1:0]    clr_addr_reg;
    logic [1:0]       func_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [IW-1:0]    addr_reg;
    logic [CW-1:0]    issue_cnt_reg;
    logic             chk_v_reg;
    logic [IW-1:0]    chk_slot_reg;
    logic             hit_reg;
    logic [IW-1:0]    hit_slot_reg;
    logic [VAL_W-1:0] hit_val_reg;
    logic             free_v_reg;
    logic [IW-1:0]    free_slot_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    hash_req_t        hreq;
    logic             hash_done;
    logic [IW-1:0]    hash_slot;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    slot_t            ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;
    slot_t            rd_slot;

    logic             accept;
    logic             out_free;
    logic             issue;
    logic             hit_now;
    logic             free_now;
    logic             scan_end;
    logic             finish;
    rsp_t             rsp_next;

    assign accept   = req_valid && (state_reg == S_IDLE);
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign rd_slot  = slot_t'(ram_rdata);
    assign issue    = (state_reg == S_SCAN) && (issue_cnt_reg != CW'(CAPACITY));
    assign hit_now  = (state_reg == S_SCAN) && chk_v_reg && rd_slot.used
                      && (rd_slot.key == key_reg);
    assign free_now = (state_reg == S_SCAN) && chk_v_reg && !rd_slot.used && !free_v_reg;
    assign scan_end = hit_now || (chk_v_reg && (issue_cnt_reg == CW'(CAPACITY)));
    assign finish   = (state_reg == S_WRITE) && out_free;

    assign hreq.start = accept && (req_data.func != FUNC_NONE);
    assign hreq.key   = req_data.key;

    lphm_hash #(
        .CAPACITY (CAPACITY)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .hreq  (hreq),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    lphm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // write port and result of the current request
    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = clr_addr_reg;
        ram_wdata  = '0;
        count_next = count_reg;
        rsp_next.found     = hit_reg;
        rsp_next.value_out = hit_reg ? hit_val_reg : '0;
        rsp_next.status    = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (finish)
        begin
            case (func_reg)
                FUNC_SET:
                begin
                    if (hit_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = hit_slot_reg;
                        ram_wdata = '{used: 1'b1, key: key_reg, value: val_reg};
                    end
                    else if (free_v_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = free_slot_reg;
                        ram_wdata  = '{used: 1'b1, key: key_reg, value: val_reg};
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        rsp_next.status = 1'b1;
                    end
                end
                FUNC_DEL:
                begin
                    if (hit_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = hit_slot_reg;
                        ram_wdata  = '{used: 1'b0, key: key_reg, value: hit_val_reg};
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        rsp_next.entry_count = ENTRY_W'(count_next);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == IW'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_data.func == FUNC_NONE) ? S_WRITE : S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            chk_v_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            free_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                hit_reg    <= 1'b0;
                free_v_reg <= 1'b0;
            end
            if (hash_done)
            begin
                chk_v_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                chk_v_reg <= issue;
            end
            if (hit_now)
            begin
                hit_reg <= 1'b1;
            end
            if (free_now)
            begin
                free_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req_data.func;
            key_reg  <= req_data.key;
            val_reg  <= req_data.value_in;
        end
        if (hash_done)
        begin
            addr_reg      <= hash_slot;
            issue_cnt_reg <= '0;
        end
        else if (issue)
        begin
            addr_reg      <= (addr_reg == IW'(CAPACITY - 1)) ? '0 : addr_reg + 1'b1;
            issue_cnt_reg <= issue_cnt_reg + 1'b1;
            chk_slot_reg  <= addr_reg;
        end
        if (hit_now)
        begin
            hit_slot_reg <= chk_slot_reg;
            hit_val_reg  <= rd_slot.value;
        end
        if (free_now)
        begin
            free_slot_reg <= chk_slot_reg;
        end
        if (finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    `ASSERT_SAME(a_count_range, 1'b1, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `ASSERT_NEXT(a_busy_after_transfer, req_valid && !req_stall, req_stall, "request taken without going busy")
    `ASSERT_SAME(a_rsp_from_write, $rose(rsp_valid), $past(state_reg == S_WRITE), "result loaded outside the write step")
    `ASSERT_SAME(a_count_moves_on_write, !$stable(count_reg), $past(state_reg == S_WRITE), "entry count changed outside the write step")

endmodule
